>>> hw/rtl/bmhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and constants of the binary min-heap queue
// Holds the heap depth, derived widths, command and status codes, and the
// request and response structs passed between the top level and the core.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	// Heap depth and the widths that follow from it.
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = ($clog2(CAPACITY + 1) > 7) ? $clog2(CAPACITY + 1) : 7;
	localparam int CHILD_W  = CNT_W + 1;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 7;

	// Command codes.
	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	// Status codes.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] value;
	} bmhq_req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] min_value;
		logic [COUNT_W-1:0]       count;
	} bmhq_rsp_t;

endpackage

>>> hw/rtl/bmhq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_core: heap store and sift sequencer
// Keeps the heap in a simple dual-port array with a registered read and
// walks sift-up and sift-down one level at a time through a single shared
// signed comparator.
// ----------------------------------------------------------------------------
module bmhq_core import bmhq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  bmhq_req_t req,
	output logic      idle,
	output logic      done,
	output bmhq_rsp_t rsp
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_UP_CHK  = 4'd1;
	localparam logic [3:0] ST_UP_CMP  = 4'd2;
	localparam logic [3:0] ST_EX_LAST = 4'd3;
	localparam logic [3:0] ST_EX_VAL  = 4'd4;
	localparam logic [3:0] ST_DN_CHK  = 4'd5;
	localparam logic [3:0] ST_DN_L    = 4'd6;
	localparam logic [3:0] ST_DN_R    = 4'd7;

	logic [3:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   pos_q;
	logic [DATA_W-1:0]  val_q;
	logic [DATA_W-1:0]  best_q;
	logic               best_left_q;
	logic [DATA_W-1:0]  min_q;

	logic [DATA_W-1:0]  mem_q [CAPACITY];
	logic [DATA_W-1:0]  rdata_q;
	logic [IDX_W-1:0]   raddr;
	logic [IDX_W-1:0]   waddr;
	logic [DATA_W-1:0]  wdata;
	logic               we;

	logic [IDX_W-1:0]   parent;
	logic [IDX_W-1:0]   last_idx;
	logic [CHILD_W-1:0] left_idx;
	logic [CHILD_W-1:0] right_idx;
	logic [CHILD_W-1:0] cnt_ext;
	logic               full;
	logic               empty;
	logic               left_out;
	logic               right_in;
	logic [DATA_W-1:0]  cmp_a;
	logic [DATA_W-1:0]  cmp_b;
	logic               cmp_lt;
	logic               right_wins;

	// Heap array: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	// Tree navigation.
	assign parent    = (pos_q - IDX_W'(1)) >> 1;
	assign last_idx  = IDX_W'(cnt_q - CNT_W'(1));
	assign left_idx  = {CNT_W'(pos_q), 1'b1};
	assign right_idx = left_idx + CHILD_W'(1);
	assign cnt_ext   = {1'b0, cnt_q};
	assign full      = (cnt_q == CNT_W'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign left_out  = (left_idx >= cnt_ext);
	assign right_in  = (right_idx < cnt_ext);

	// Shared signed comparator: a < b.
	always_comb begin
		cmp_a = rdata_q;
		cmp_b = val_q;
		case (state_q)
			ST_UP_CMP: begin
				cmp_a = val_q;
				cmp_b = rdata_q;
			end
			ST_DN_R: begin
				cmp_a = rdata_q;
				cmp_b = best_q;
			end
			default: begin
				cmp_a = rdata_q;
				cmp_b = val_q;
			end
		endcase
	end
	assign cmp_lt     = ($signed(cmp_a) < $signed(cmp_b));
	assign right_wins = right_in && cmp_lt;

	// Memory port control and completion.
	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = val_q;
		raddr = '0;
		done  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start && (req.cmd == CMD_INSERT) && full) begin
					done = 1'b1;
				end
				if (start && (req.cmd == CMD_EXTRACT) && empty) begin
					done = 1'b1;
				end
			end
			ST_UP_CHK: begin
				if (pos_q == '0) begin
					we   = 1'b1;
					done = 1'b1;
				end else begin
					raddr = parent;
				end
			end
			ST_UP_CMP: begin
				we = 1'b1;
				if (cmp_lt) begin
					wdata = rdata_q;
				end else begin
					done = 1'b1;
				end
			end
			ST_EX_LAST: begin
				raddr = last_idx;
			end
			ST_DN_CHK: begin
				if (left_out) begin
					we   = 1'b1;
					done = 1'b1;
				end else begin
					raddr = left_idx[IDX_W-1:0];
				end
			end
			ST_DN_L: begin
				raddr = right_idx[IDX_W-1:0];
			end
			ST_DN_R: begin
				we = 1'b1;
				if (right_wins) begin
					wdata = rdata_q;
				end else if (best_left_q) begin
					wdata = best_q;
				end else begin
					done = 1'b1;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Sequencer state and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && (req.cmd == CMD_INSERT) && !full) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_UP_CHK;
					end
					if (start && (req.cmd == CMD_EXTRACT) && !empty) begin
						state_q <= ST_EX_LAST;
					end
				end
				ST_UP_CHK: begin
					state_q <= (pos_q == '0) ? ST_IDLE : ST_UP_CMP;
				end
				ST_UP_CMP: begin
					state_q <= cmp_lt ? ST_UP_CHK : ST_IDLE;
				end
				ST_EX_LAST: begin
					cnt_q   <= cnt_q - CNT_W'(1);
					state_q <= ST_EX_VAL;
				end
				ST_EX_VAL: begin
					state_q <= ST_DN_CHK;
				end
				ST_DN_CHK: begin
					state_q <= left_out ? ST_IDLE : ST_DN_L;
				end
				ST_DN_L: begin
					state_q <= ST_DN_R;
				end
				ST_DN_R: begin
					state_q <= (right_wins || best_left_q) ? ST_DN_CHK : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: moving value, position, best child and minimum.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start && (req.cmd == CMD_INSERT)) begin
					min_q <= '0;
					val_q <= req.value;
					pos_q <= cnt_q[IDX_W-1:0];
				end
			end
			ST_UP_CMP: begin
				if (cmp_lt) begin
					pos_q <= parent;
				end
			end
			ST_EX_LAST: begin
				min_q <= rdata_q;
			end
			ST_EX_VAL: begin
				val_q <= rdata_q;
				pos_q <= '0;
			end
			ST_DN_L: begin
				best_q      <= cmp_lt ? rdata_q : val_q;
				best_left_q <= cmp_lt;
			end
			ST_DN_R: begin
				if (right_wins) begin
					pos_q <= right_idx[IDX_W-1:0];
				end else if (best_left_q) begin
					pos_q <= left_idx[IDX_W-1:0];
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// Result of the command that completes this cycle.
	always_comb begin
		rsp.count = cnt_q[COUNT_W-1:0];
		if (state_q == ST_IDLE) begin
			rsp.status    = (req.cmd == CMD_INSERT) ? STATUS_FULL : STATUS_EMPTY;
			rsp.min_value = '0;
		end else begin
			rsp.status    = STATUS_OK;
			rsp.min_value = min_q;
		end
	end

	assign idle = (state_q == ST_IDLE);

endmodule

>>> hw/rtl/binary_min_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue: priority queue of signed 32-bit values
// A command beat on the input channel (cmd, value) either inserts value or
// extracts the minimum. Each command returns exactly one result beat on the
// output channel: status (ok, empty or full), the removed minimum on a good
// extract (zero otherwise) and the entry count after the command.
// A rejected command completes straight from idle. An insert climbs from the
// new leaf one level at a time, reading the parent and moving it down while
// the value is smaller; an extract takes the root as the minimum, moves the
// last entry to the root and sinks it, reading the left and then the right
// child and comparing each, until it reaches a leaf or neither child is
// smaller. Every read of the heap array is registered and every compare is
// signed and goes through a single shared comparator.
// The block takes one command at a time: in_ready is high only while the
// sequencer is idle and the output register is empty, so a stalled receiver
// holds off the next command. Reset empties the heap at once; the array
// contents are not cleared and entries are only read after being written.
// ----------------------------------------------------------------------------
module binary_min_heap_queue import bmhq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     cmd,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] min_value,
	output logic [COUNT_W-1:0]       count
);

	bmhq_req_t req;
	bmhq_rsp_t rsp;
	logic      core_idle;
	logic      core_done;
	logic      start;
	logic      out_valid_q;
	bmhq_rsp_t rsp_q;

	// Command beat into the sequencer.
	assign req.cmd   = cmd;
	assign req.value = value;
	assign in_ready  = core_idle && !out_valid_q;
	assign start     = in_valid && in_ready;

	bmhq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.idle   (core_idle),
		.done   (core_done),
		.rsp    (rsp)
	);

	// Output register holds the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) begin
			rsp_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = rsp_q.status;
	assign min_value = rsp_q.min_value;
	assign count     = rsp_q.count;

`ifndef NO_ASSERTIONS
	// A command is only taken when no result is pending.
	a_ready_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("in_ready high while a result is pending");

	// Once a command is taken, no second one is taken on the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second command accepted back to back");

	// A full rejection reports a full heap.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STATUS_FULL)) |-> (count == COUNT_W'(CAPACITY)))
		else $error("full status with count below capacity");

	// An empty rejection reports an empty heap and no value.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STATUS_EMPTY)) |-> ((count == '0) && (min_value == '0)))
		else $error("empty status with nonzero count or value");
`endif

endmodule
